### rtl/wmsd_pkg.sv
// Shared types and constants for the windowed minimum-SAD descriptor search.
// Used by the top level; depends on nothing else.
`default_nettype none

package wmsd_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned VALUE_W   = 8;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned SAD_W     = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 12;
  localparam int unsigned MODE_W    = 2;

  localparam int unsigned DESC_LEN_DEF       = 32;
  localparam int unsigned MAX_CANDIDATES_DEF = 1024;
  localparam int unsigned VALUE_BITS_DEF     = 8;
  localparam int unsigned IDX_MAX            = 1023;

  localparam logic [SAD_W-1:0]   SAD_MAX       = '1;
  localparam logic [COORD_W-1:0] WINDOW_RESET  = 12'd50;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 4'd1;

  localparam logic [MODE_W-1:0] GATE_AREA          = 2'd0;
  localparam logic [MODE_W-1:0] GATE_STRIP_LESS    = 2'd1;
  localparam logic [MODE_W-1:0] GATE_STRIP_GREATER = 2'd2;

  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_CAND  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] point_row;
    logic [COORD_W-1:0] point_col;
    logic [VALUE_W-1:0] desc_value;
    logic               last_element;
    logic               last_candidate;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] best_index;
    logic [SAD_W-1:0] best_sad;
    logic             best_in_window;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_item_t;

endpackage

`default_nettype wire

### rtl/wmsd_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
// The payload type is chosen per instance from wmsd_pkg.
`default_nettype none

interface wmsd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/windowed_min_sad_descriptor_search.sv
// Top level of the windowed minimum-SAD descriptor search.
// Depends on wmsd_pkg and wmsd_stream_if.
//
// The block stores a query descriptor, then takes candidate descriptors one element per
// transaction and reports the best candidate on the last element of the last candidate.
// It accepts one element every cycle unless the output stalls it: the query descriptor sits in a
// single-port-write, single-port-read memory that is read in the cycle an element is
// taken, and the absolute difference and saturating accumulate work on the registered
// element and read data. A result enters the output register when the closing element
// leaves the accumulate stage; the input stalls only while a result waits in that
// register and the next closing element is ready to produce another. The query memory
// needs no clearing after reset, so elements are accepted from the first cycle.
`default_nettype none

module windowed_min_sad_descriptor_search #(
  parameter int unsigned DESC_LEN       = wmsd_pkg::DESC_LEN_DEF,
  parameter int unsigned MAX_CANDIDATES = wmsd_pkg::MAX_CANDIDATES_DEF,
  parameter int unsigned VALUE_BITS     = wmsd_pkg::VALUE_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  wmsd_stream_if.sink    in_i,
  wmsd_stream_if.sink    cfg_i,
  wmsd_stream_if.source  res_o
);

  localparam int unsigned PW = $clog2(DESC_LEN + 1);
  localparam int unsigned AW = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
  localparam int unsigned VW = (VALUE_BITS < wmsd_pkg::VALUE_W) ? VALUE_BITS
                                                                : wmsd_pkg::VALUE_W;
  localparam int unsigned LIM_INT = (MAX_CANDIDATES - 1 > wmsd_pkg::IDX_MAX)
                                    ? wmsd_pkg::IDX_MAX : MAX_CANDIDATES - 1;
  localparam logic [wmsd_pkg::IDX_W-1:0] POS_LIMIT = wmsd_pkg::IDX_W'(LIM_INT);
  localparam logic [PW-1:0] DESC_END = PW'(DESC_LEN);

  typedef struct packed {
    logic                         action;
    logic                         pos_valid;
    logic                         first;
    logic                         last_element;
    logic                         last_candidate;
    logic                         gated;
    logic [VW-1:0]                value;
    logic [wmsd_pkg::IDX_W-1:0]   cand_pos;
  } s1_t;

  // Configuration registers.
  logic [wmsd_pkg::MODE_W-1:0]  gate_mode_q;
  logic [wmsd_pkg::COORD_W-1:0] window_size_q;

  // Front stage state.
  logic [wmsd_pkg::COORD_W-1:0] query_row_q, query_row_d;
  logic [wmsd_pkg::COORD_W-1:0] query_col_q, query_col_d;
  logic [PW-1:0]                elem_pos_q, elem_pos_d;
  logic [wmsd_pkg::IDX_W-1:0]   cand_pos_q, cand_pos_d;
  logic                         cand_gated_q, cand_gated_d;

  // Accumulate stage state.
  logic                         s1_valid_q;
  s1_t                          s1_q, s1_d;
  logic [VW-1:0]                rd_data_q;
  logic [wmsd_pkg::SAD_W-1:0]   running_sad_q, running_sad_d;
  logic [wmsd_pkg::SAD_W-1:0]   best_sum_q, best_sum_d;
  logic [wmsd_pkg::IDX_W-1:0]   best_pos_q, best_pos_d;
  logic                         best_gated_q, best_gated_d;

  // Output register.
  logic                         out_valid_q;
  wmsd_pkg::out_item_t          out_q;

  logic [VW-1:0]                qmem [DESC_LEN];

  wmsd_pkg::in_item_t           in_item;
  wmsd_pkg::cfg_item_t          cfg_item;
  logic                         in_fire;
  logic                         cfg_fire;
  logic                         s1_emit;
  logic                         s1_advance;
  logic                         pos_valid;
  logic                         pos_first;
  logic                         gate_now;
  logic [AW-1:0]                mem_addr;
  logic                         mem_we;
  logic [VW-1:0]                in_value;
  logic [VW-1:0]                abs_diff;
  logic [wmsd_pkg::SAD_W-1:0]   sum_base;
  logic [wmsd_pkg::SAD_W:0]     sum_wide;
  logic [wmsd_pkg::SAD_W-1:0]   sum_new;

  function automatic logic [wmsd_pkg::COORD_W-1:0] coord_dist(
    input logic [wmsd_pkg::COORD_W-1:0] a,
    input logic [wmsd_pkg::COORD_W-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  assign in_item  = in_i.payload;
  assign cfg_item = cfg_i.payload;

  assign s1_emit    = s1_q.action && s1_q.last_element && s1_q.last_candidate;
  assign s1_advance = s1_valid_q && (!s1_emit || !out_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;
  assign in_fire    = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_mode_q   <= wmsd_pkg::GATE_AREA;
      window_size_q <= wmsd_pkg::WINDOW_RESET;
    end else if (cfg_fire) begin
      case (cfg_item.index)
        wmsd_pkg::CFG_GATE_MODE: begin
          gate_mode_q <= cfg_item.data[wmsd_pkg::MODE_W-1:0];
        end
        wmsd_pkg::CFG_WINDOW_SIZE: begin
          window_size_q <= cfg_item.data;
        end
        default: begin
        end
      endcase
    end
  end

  // Front stage: element bookkeeping, window gate and query memory access.
  assign pos_valid = elem_pos_q < DESC_END;
  assign pos_first = elem_pos_q == '0;
  assign mem_addr  = elem_pos_q[AW-1:0];
  assign in_value  = in_item.desc_value[VW-1:0];
  assign mem_we    = in_fire && (in_item.action == wmsd_pkg::ACT_QUERY) && pos_valid;

  always_comb begin
    logic row_ok;
    row_ok = coord_dist(in_item.point_row, query_row_q) <= window_size_q;
    case (gate_mode_q)
      wmsd_pkg::GATE_AREA: begin
        gate_now = row_ok && (coord_dist(in_item.point_col, query_col_q) <= window_size_q);
      end
      wmsd_pkg::GATE_STRIP_LESS: begin
        gate_now = row_ok && (in_item.point_col < query_col_q);
      end
      wmsd_pkg::GATE_STRIP_GREATER: begin
        gate_now = row_ok && (in_item.point_col > query_col_q);
      end
      default: begin
        gate_now = 1'b0;
      end
    endcase
  end

  always_comb begin
    query_row_d  = query_row_q;
    query_col_d  = query_col_q;
    elem_pos_d   = elem_pos_q;
    cand_pos_d   = cand_pos_q;
    cand_gated_d = cand_gated_q;
    if (in_item.action == wmsd_pkg::ACT_QUERY) begin
      if (pos_first) begin
        query_row_d = in_item.point_row;
        query_col_d = in_item.point_col;
      end
      if (in_item.last_element) begin
        elem_pos_d = '0;
        cand_pos_d = '0;
      end else if (pos_valid) begin
        elem_pos_d = elem_pos_q + PW'(1);
      end
    end else begin
      if (pos_first) begin
        cand_gated_d = gate_now;
      end
      if (!in_item.last_element) begin
        if (pos_valid) begin
          elem_pos_d = elem_pos_q + PW'(1);
        end
      end else begin
        elem_pos_d = '0;
        if (in_item.last_candidate) begin
          cand_pos_d = '0;
        end else if (cand_pos_q < POS_LIMIT) begin
          cand_pos_d = cand_pos_q + wmsd_pkg::IDX_W'(1);
        end
      end
    end
    s1_d.action         = in_item.action;
    s1_d.pos_valid      = pos_valid;
    s1_d.first          = pos_first;
    s1_d.last_element   = in_item.last_element;
    s1_d.last_candidate = in_item.last_candidate;
    s1_d.gated          = cand_gated_d;
    s1_d.value          = in_value;
    s1_d.cand_pos       = cand_pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_row_q  <= '0;
      query_col_q  <= '0;
      elem_pos_q   <= '0;
      cand_pos_q   <= '0;
      cand_gated_q <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        query_row_q  <= query_row_d;
        query_col_q  <= query_col_d;
        elem_pos_q   <= elem_pos_d;
        cand_pos_q   <= cand_pos_d;
        cand_gated_q <= cand_gated_d;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      qmem[mem_addr] <= in_value;
    end
    if (in_fire) begin
      rd_data_q <= qmem[mem_addr];
      s1_q      <= s1_d;
    end
  end

  // Accumulate stage: absolute difference, saturating sum and best update.
  assign abs_diff = (s1_q.value > rd_data_q) ? (s1_q.value - rd_data_q)
                                             : (rd_data_q - s1_q.value);
  assign sum_base = s1_q.first ? '0 : running_sad_q;
  assign sum_wide = {1'b0, sum_base}
                  + (s1_q.pos_valid ? (wmsd_pkg::SAD_W + 1)'(abs_diff) : '0);
  assign sum_new  = sum_wide[wmsd_pkg::SAD_W] ? wmsd_pkg::SAD_MAX
                                              : sum_wide[wmsd_pkg::SAD_W-1:0];

  always_comb begin
    running_sad_d = running_sad_q;
    best_sum_d    = best_sum_q;
    best_pos_d    = best_pos_q;
    best_gated_d  = best_gated_q;
    if (s1_q.action == wmsd_pkg::ACT_CAND) begin
      running_sad_d = sum_new;
      if (s1_q.last_element) begin
        if (s1_q.cand_pos == '0) begin
          best_sum_d   = sum_new;
          best_pos_d   = '0;
          best_gated_d = s1_q.gated;
        end else if (s1_q.gated && (sum_new < best_sum_q)) begin
          best_sum_d   = sum_new;
          best_pos_d   = s1_q.cand_pos;
          best_gated_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sad_q <= '0;
      best_sum_q    <= '0;
      best_pos_q    <= '0;
      best_gated_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (s1_advance) begin
        running_sad_q <= running_sad_d;
        best_sum_q    <= best_sum_d;
        best_pos_q    <= best_pos_d;
        best_gated_q  <= best_gated_d;
      end
      if (s1_advance && s1_emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_emit) begin
      out_q.best_index     <= best_pos_d;
      out_q.best_sad       <= best_sum_d;
      out_q.best_in_window <= best_gated_d;
    end
  end

  a_elem_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_pos_q <= DESC_END)
    else $error("element position beyond the descriptor length");

  a_cand_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_pos_q <= POS_LIMIT)
    else $error("candidate position beyond its limit");

  a_ungated_is_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.best_in_window) |-> (out_q.best_index == '0))
    else $error("a candidate outside the window replaced the first candidate");

  a_no_emit_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> out_valid_q)
    else $error("a pending result was dropped");

endmodule

`default_nettype wire
